[rtl/core/irm_pkg.sv]
// Package for the interval range map: table size, request and response types,
// status codes and register addresses. No dependencies.
`timescale 1ns / 1ps
package irm_pkg;
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = 40;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [2:0] REG_DEFAULT_VALUE = 3'd0;

   typedef struct packed {
      logic op;
      logic signed [31:0] key_begin;
      logic signed [31:0] key_end;
      logic [7:0] new_value;
      logic signed [31:0] query_key;
   } req_type;

   typedef struct packed {
      logic [7:0] found_value;
      logic [1:0] status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture request, clear counters
      logic scan;       // compare the entry read last cycle
      logic [IDX_W-1:0] rd_addr;
      logic wr_en;      // write to the scratch table
      logic wr_sel;     // 0 scratch, 1 count register
      logic [1:0] wr_src; // 0 old entry, 1 begin, 2 end
      logic [IDX_W-1:0] wr_addr;
      logic [CNT_W-1:0] new_count; // breakpoint count after a rebuild
      logic copy;       // main write takes scratch read data
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op;
      logic empty;
      logic full;
      logic rd_above;
      logic [CNT_W-1:0] below;
      logic [CNT_W-1:0] count;
      logic [7:0] found;
   } stat_type;

   localparam logic [1:0] SRC_OLD = 2'd0;
   localparam logic [1:0] SRC_BEGIN = 2'd1;
   localparam logic [1:0] SRC_END = 2'd2;
endpackage

[rtl/core/irm_ram.sv]
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module irm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/core/irm_datapath.sv]
// Datapath of the interval range map: request register, main and scratch
// tables, scan compares and counters. Depends on irm_pkg and irm_ram.
`timescale 1ns / 1ps
module irm_datapath import irm_pkg::*; (
   input logic clock,
   input logic reset,
   input req_type req,
   input logic [7:0] default_value,
   input cmd_type cmd,
   output stat_type stat
);
   req_type req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] below_ff, above_ff;
   logic [7:0] found_ff, endval_ff;
   logic [ENTRY_W-1:0] main_rd, tmp_rd, wr_data, main_wd;
   logic signed [31:0] rd_key, probe;
   logic rd_lt, rd_gt, rd_le_end, rd_le_q;
   logic [CNT_W:0] need;

   assign rd_key = main_rd[ENTRY_W-1:8];
   assign probe = (req_ff.op == OP_LOOKUP) ? req_ff.query_key : req_ff.key_end;
   assign rd_lt = rd_key < req_ff.key_begin;
   assign rd_gt = rd_key > req_ff.key_end;
   assign rd_le_end = rd_key <= probe;
   assign rd_le_q = rd_le_end;

   always_comb begin
      case (cmd.wr_src)
         SRC_BEGIN: wr_data = {req_ff.key_begin, req_ff.new_value};
         SRC_END: wr_data = {req_ff.key_end, endval_ff};
         default: wr_data = main_rd;
      endcase
   end
   assign main_wd = tmp_rd;

   irm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_main (
      .clock(clock), .wr_en(cmd.copy), .wr_addr(cmd.wr_addr), .wr_data(main_wd),
      .rd_addr(cmd.rd_addr), .rd_data(main_rd));
   irm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_tmp (
      .clock(clock), .wr_en(cmd.wr_en & ~cmd.wr_sel), .wr_addr(cmd.wr_addr),
      .wr_data(wr_data), .rd_addr(cmd.rd_addr), .rd_data(tmp_rd));

   always_comb begin
      count_in = count_ff;
      if (cmd.wr_en && cmd.wr_sel) begin
         count_in = cmd.new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (cmd.load) begin
         req_ff <= req;
         below_ff <= '0;
         above_ff <= '0;
         found_ff <= default_value;
         endval_ff <= default_value;
      end else if (cmd.scan) begin
         if (rd_lt) below_ff <= below_ff + 1'b1;
         if (rd_gt) above_ff <= above_ff + 1'b1;
         if (rd_le_q) begin
            found_ff <= main_rd[7:0];
            endval_ff <= main_rd[7:0];
         end
      end
   end

   assign need = {1'b0, below_ff} + {1'b0, above_ff} + 2'd2;
   assign stat.op = req_ff.op;
   assign stat.empty = !(req_ff.key_begin < req_ff.key_end);
   assign stat.full = need > (CNT_W + 1)'(TABLE_ENTRIES);
   assign stat.rd_above = rd_gt;
   assign stat.below = below_ff;
   assign stat.count = count_ff;
   assign stat.found = found_ff;
endmodule

[rtl/core/irm_control.sv]
// Sequencer of the interval range map: count scan, then, for a performed
// assign, rebuild into the scratch table and copy back; respond. Depends on irm_pkg.
`timescale 1ns / 1ps
module irm_control import irm_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp,
   input stat_type stat,
   output cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_BUILD = 3'd3;
   localparam logic [2:0] S_COPY = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;     // read pointer
   logic [CNT_W-1:0] wp_ff, wp_in;       // scratch write pointer
   logic pend_ff, pend_in;               // a read is in flight
   logic phase_ff, phase_in;             // build: 0 below part, 1 above part
   logic ins_ff, ins_in;                 // begin/end inserted
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] last;

   assign last = stat.count;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      wp_in = wp_ff;
      pend_in = 1'b0;
      phase_in = phase_ff;
      ins_in = ins_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      cmd.rd_addr = idx_ff[IDX_W-1:0];
      cmd.wr_addr = wp_ff[IDX_W-1:0];
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               idx_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = pend_ff;
            if (idx_ff < last) begin
               pend_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            idx_in = '0;
            wp_in = '0;
            phase_in = 1'b0;
            ins_in = 1'b0;
            if (stat.op == OP_LOOKUP) begin
               rsp_in = '{found_value: stat.found, status: STATUS_DONE};
               state_in = S_RESP;
            end else if (stat.empty) begin
               rsp_in = '{found_value: 8'd0, status: STATUS_EMPTY};
               state_in = S_RESP;
            end else if (stat.full) begin
               rsp_in = '{found_value: 8'd0, status: STATUS_FULL};
               state_in = S_RESP;
            end else begin
               rsp_in = '{found_value: 8'd0, status: STATUS_DONE};
               state_in = S_BUILD;
            end
         end
         S_BUILD: begin
            // Entries below begin occupy the first stat.below slots.
            if (!phase_ff) begin
               if (pend_ff) begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_src = SRC_OLD;
                  wp_in = wp_ff + 1'b1;
               end
               if (idx_ff < stat.below) begin
                  pend_in = 1'b1;
                  idx_in = idx_ff + 1'b1;
               end else if (!pend_ff) begin
                  phase_in = 1'b1;
               end
            end else if (ins_ff == 1'b0) begin
               cmd.wr_en = 1'b1;
               cmd.wr_src = (wp_ff == stat.below) ? SRC_BEGIN : SRC_END;
               wp_in = wp_ff + 1'b1;
               if (wp_ff != stat.below) ins_in = 1'b1;
            end else begin
               cmd.wr_en = pend_ff && stat.rd_above;
               cmd.wr_src = SRC_OLD;
               if (cmd.wr_en) wp_in = wp_ff + 1'b1;
               if (idx_ff < last) begin
                  pend_in = 1'b1;
                  idx_in = idx_ff + 1'b1;
               end else if (!pend_ff) begin
                  idx_in = '0;
                  state_in = S_COPY;
               end
            end
         end
         S_COPY: begin
            // Scratch read data for idx-1 is written to main at idx-1.
            cmd.copy = pend_ff;
            cmd.wr_addr = IDX_W'(idx_ff - 1'b1);
            if (idx_ff < wp_ff) begin
               pend_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               cmd.wr_en = 1'b1;
               cmd.wr_sel = 1'b1;
               cmd.wr_addr = wp_ff[IDX_W-1:0];
               cmd.new_count = wp_ff;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
      end
      idx_ff <= idx_in;
      wp_ff <= wp_in;
      phase_ff <= phase_in;
      ins_ff <= ins_in;
      rsp_ff <= rsp_in;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("request taken while busy");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("response dropped");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(TABLE_ENTRIES)) else $error("table count overflow");
endmodule

[rtl/core/interval_range_map.sv]
// Top level of the interval range map: configuration register, controller
// and datapath. Depends on irm_pkg, irm_control and irm_datapath.
`timescale 1ns / 1ps
// A lookup, an empty assign and a refused assign raise rsp_valid after a scan
// of the table. A performed assign scans the table, rebuilds it into a scratch
// table and copies it back, each pass walking a single RAM read port one entry
// per cycle. One request is in work at a time, and the next request is taken
// only after the response has left its output register.
module interval_range_map import irm_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [2:0] paddr,
   input logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   logic [7:0] default_ff;
   cmd_type cmd;
   stat_type stat;

   assign pready = 1'b1;
   assign prdata = (paddr == REG_DEFAULT_VALUE) ? {24'd0, default_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= 8'd0;
      end else if (psel && penable && pwrite && paddr == REG_DEFAULT_VALUE) begin
         default_ff <= pwdata[7:0];
      end
   end

   irm_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp_data),
      .stat(stat), .cmd(cmd));
   irm_datapath u_datapath (
      .clock(clock), .reset(reset), .req(req_data), .default_value(default_ff),
      .cmd(cmd), .stat(stat));
endmodule
